### rtl/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg
// shared types and constants of the pinhole box projection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

  localparam int IMAGE_WIDTH_DEF  = 2048;
  localparam int IMAGE_HEIGHT_DEF = 1536;

  localparam int LANES  = 6;
  localparam int NBITS  = 64;
  localparam int QBITS  = 41;
  localparam int ADDR_W = 5;

  // lane order: centre, minus corner, plus corner; u on even lanes, v on odd
  localparam int LANE_U0 = 0;
  localparam int LANE_V0 = 1;
  localparam int LANE_U1 = 2;
  localparam int LANE_V1 = 3;
  localparam int LANE_U2 = 4;
  localparam int LANE_V2 = 5;

  localparam logic [30:0]      HALF_SIZE_RESET = 31'd3277;
  localparam logic [QBITS-1:0] QUOT_CLAMP      = {1'b1, {(QBITS-1){1'b0}}};

  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = QBITS + 1;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  typedef enum logic [2:0] {
    REG_FOCAL_U,
    REG_FOCAL_V,
    REG_CENTER_U,
    REG_CENTER_V,
    REG_SHIFT_U,
    REG_SHIFT_V,
    REG_HALF_SIZE
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] focal_u;
    logic [30:0] focal_v;
    logic [31:0] center_u;
    logic [31:0] center_v;
    logic [31:0] shift_u;
    logic [31:0] shift_v;
    logic [30:0] half_size;
  } cfg_t;

  typedef struct packed {
    logic             qneg;
    logic [NBITS-1:0] nmag;
  } div_in_t;

  typedef struct packed {
    logic             qneg;
    logic             clamp;
    logic             kill;
    logic [QBITS-1:0] quot;
  } div_out_t;

endpackage

`default_nettype wire

### rtl/pbp_cfg.sv
// ----------------------------------------------------------------------------
// pbp_cfg
// apb register file holding the camera intrinsics and box size
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_cfg
  import pbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [30:0] focal_u;
  logic [30:0] focal_v;
  logic [31:0] center_u;
  logic [31:0] center_v;
  logic [31:0] shift_u;
  logic [31:0] shift_v;
  logic [30:0] half_size;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_u   <= '0;
      focal_v   <= '0;
      center_u  <= '0;
      center_v  <= '0;
      shift_u   <= '0;
      shift_v   <= '0;
      half_size <= HALF_SIZE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FOCAL_U:   focal_u   <= pwdata[30:0];
        REG_FOCAL_V:   focal_v   <= pwdata[30:0];
        REG_CENTER_U:  center_u  <= pwdata;
        REG_CENTER_V:  center_v  <= pwdata;
        REG_SHIFT_U:   shift_u   <= pwdata;
        REG_SHIFT_V:   shift_v   <= pwdata;
        REG_HALF_SIZE: half_size <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FOCAL_U:   prdata = {1'b0, focal_u};
      REG_FOCAL_V:   prdata = {1'b0, focal_v};
      REG_CENTER_U:  prdata = center_u;
      REG_CENTER_V:  prdata = center_v;
      REG_SHIFT_U:   prdata = shift_u;
      REG_SHIFT_V:   prdata = shift_v;
      REG_HALF_SIZE: prdata = {1'b0, half_size};
      default:       prdata = '0;
    endcase
  end

  assign cfg.focal_u   = focal_u;
  assign cfg.focal_v   = focal_v;
  assign cfg.center_u  = center_u;
  assign cfg.center_v  = center_v;
  assign cfg.shift_u   = shift_u;
  assign cfg.shift_v   = shift_v;
  assign cfg.half_size = half_size;

endmodule

`default_nettype wire

### rtl/pbp_front.sv
// ----------------------------------------------------------------------------
// pbp_front
// corner coordinates, focal products and signed numerators for six lanes
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_front
  import pbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [31:0]             point_x,
  input  logic [31:0]             point_y,
  input  logic [31:0]             point_z,
  input  cfg_t                    cfg,
  output logic                    out_valid,
  output logic                    out_zpos,
  output logic [31:0]             out_zmag,
  output div_in_t [LANES-1:0]     out_num
);

  logic               v1, v2, v3, v4;
  logic [31:0]        px1, py1, pz1, pz2, pz3, pz4;
  logic signed [32:0] cx, cy, hext;
  logic signed [32:0] coord [LANES];
  logic signed [32:0] coord2 [LANES];
  logic signed [64:0] prod_full [LANES];
  logic signed [63:0] prod3 [LANES];
  logic signed [64:0] toff_u, toff_v;
  logic signed [64:0] num [LANES];
  logic signed [64:0] num4 [LANES];
  logic [NBITS-1:0]   mag [LANES];
  logic [31:0]        zmag;

  // swapped axes
  always_comb begin
    cx   = {py1[31], py1};
    cy   = {px1[31], px1};
    hext = {2'b00, cfg.half_size};
    coord[LANE_U0] = cx;
    coord[LANE_V0] = cy;
    coord[LANE_U1] = cx - hext;
    coord[LANE_V1] = cy - hext;
    coord[LANE_U2] = cx + hext;
    coord[LANE_V2] = cy + hext;
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if ((l % 2) != 0) begin
        prod_full[l] = coord2[l] * $signed({1'b0, cfg.focal_v});
      end else begin
        prod_full[l] = coord2[l] * $signed({1'b0, cfg.focal_u});
      end
    end
  end

  // v lanes use the negated coordinate
  always_comb begin
    toff_u = {{17{cfg.shift_u[31]}}, cfg.shift_u, 16'd0};
    toff_v = {{17{cfg.shift_v[31]}}, cfg.shift_v, 16'd0};
    for (int l = 0; l < LANES; l++) begin
      if ((l % 2) != 0) begin
        num[l] = toff_v - {prod3[l][63], prod3[l]};
      end else begin
        num[l] = toff_u + {prod3[l][63], prod3[l]};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = num4[l][64] ? NBITS'(-num4[l]) : num4[l][NBITS-1:0];
    end
    zmag = pz4[31] ? (~pz4 + 32'd1) : pz4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    px1 <= point_x;
    py1 <= point_y;
    pz1 <= point_z;
    pz2 <= pz1;
    pz3 <= pz2;
    pz4 <= pz3;
    for (int l = 0; l < LANES; l++) begin
      coord2[l]          <= coord[l];
      prod3[l]           <= prod_full[l][63:0];
      num4[l]            <= num[l];
      out_num[l].qneg    <= num4[l][64] ^ pz4[31];
      out_num[l].nmag    <= mag[l];
    end
    out_zmag <= zmag;
    out_zpos <= !pz4[31] && (pz4 != '0);
  end

endmodule

`default_nettype wire

### rtl/pbp_div.sv
// ----------------------------------------------------------------------------
// pbp_div
// six-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_div
  import pbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_zpos,
  input  logic [31:0]          in_zmag,
  input  div_in_t [LANES-1:0]  in_num,
  output logic                 out_valid,
  output logic                 out_zpos,
  output div_out_t [LANES-1:0] out_quot
);

  logic [QBITS:0]   vld;
  logic [QBITS:0]   zpos;
  logic [QBITS:0]   kill;
  logic [31:0]      zmag [QBITS+1];
  logic [31:0]      rem  [QBITS+1][LANES];
  logic [QBITS-1:0] shr  [QBITS+1][LANES];
  logic             qneg [QBITS+1][LANES];
  logic             clamp [QBITS+1][LANES];

  logic [32:0]      rem2 [QBITS][LANES];
  logic [32:0]      diff [QBITS][LANES];
  logic             ge   [QBITS][LANES];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        rem2[k][l] = {rem[k][l], shr[k][l][QBITS-1]};
        diff[k][l] = rem2[k][l] - {1'b0, zmag[k]};
        ge[k][l]   = rem2[k][l] >= {1'b0, zmag[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QBITS-1:0], in_valid};
    end
  end

  // quotient at or above 2^41 is caught before the bit loop
  always_ff @(posedge clk) begin
    zpos    <= {zpos[QBITS-1:0], in_zpos};
    kill    <= {kill[QBITS-1:0], in_zmag == '0};
    zmag[0] <= in_zmag;
    for (int l = 0; l < LANES; l++) begin
      rem[0][l]   <= 32'(in_num[l].nmag[NBITS-1:QBITS]);
      shr[0][l]   <= in_num[l].nmag[QBITS-1:0];
      qneg[0][l]  <= in_num[l].qneg;
      clamp[0][l] <= (32'(in_num[l].nmag[NBITS-1:QBITS]) >= in_zmag)
                     && (in_num[l].nmag != '0);
    end
    for (int k = 0; k < QBITS; k++) begin
      zmag[k+1] <= zmag[k];
      for (int l = 0; l < LANES; l++) begin
        rem[k+1][l]   <= ge[k][l] ? diff[k][l][31:0] : rem2[k][l][31:0];
        shr[k+1][l]   <= {shr[k][l][QBITS-2:0], ge[k][l]};
        qneg[k+1][l]  <= qneg[k][l];
        clamp[k+1][l] <= clamp[k][l];
      end
    end
  end

  assign out_valid = vld[QBITS];
  assign out_zpos  = zpos[QBITS];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quot[l].qneg  = qneg[QBITS][l];
      out_quot[l].clamp = clamp[QBITS][l];
      out_quot[l].kill  = kill[QBITS];
      out_quot[l].quot  = shr[QBITS][l];
    end
  end

endmodule

`default_nettype wire

### rtl/pbp_back.sv
// ----------------------------------------------------------------------------
// pbp_back
// quotient clamp, principal point, saturation and view test
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_back
  import pbp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_zpos,
  input  div_out_t [LANES-1:0] in_quot,
  input  cfg_t                 cfg,
  output logic                 done,
  output logic                 in_view,
  output logic signed [31:0]   corner_a_u,
  output logic signed [31:0]   corner_a_v,
  output logic signed [31:0]   corner_b_u,
  output logic signed [31:0]   corner_b_v
);

  localparam logic signed [42:0] WB     = 43'(IMAGE_WIDTH) <<< 16;
  localparam logic signed [42:0] HB     = 43'(IMAGE_HEIGHT) <<< 16;
  localparam logic signed [42:0] SAT_HI = 43'sh000_7fff_ffff;
  localparam logic signed [42:0] SAT_LO = 43'sh7ff_8000_0000;

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = 32'h7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic               v1, v2;
  logic               zpos1, zpos2;
  logic [QBITS-1:0]   qmag [LANES];
  logic [QBITS-1:0]   qmag1 [LANES];
  logic               qneg1 [LANES];
  logic signed [42:0] cen [LANES];
  logic signed [42:0] val [LANES];
  logic signed [42:0] val2 [LANES];
  logic               ok;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (in_quot[l].clamp) begin
        qmag[l] = QUOT_CLAMP;
      end else if (in_quot[l].kill) begin
        qmag[l] = '0;
      end else if (in_quot[l].quot > QUOT_CLAMP) begin
        qmag[l] = QUOT_CLAMP;
      end else begin
        qmag[l] = in_quot[l].quot;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if ((l % 2) != 0) begin
        cen[l] = {{11{cfg.center_v[31]}}, cfg.center_v};
      end else begin
        cen[l] = {{11{cfg.center_u[31]}}, cfg.center_u};
      end
      val[l] = qneg1[l] ? cen[l] - {2'b00, qmag1[l]} : cen[l] + {2'b00, qmag1[l]};
    end
  end

  assign ok = zpos2
              && (val2[LANE_U0] > -WB) && (val2[LANE_U0] < WB)
              && (val2[LANE_V0] > -HB) && (val2[LANE_V0] < HB);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    zpos1 <= in_zpos;
    zpos2 <= zpos1;
    for (int l = 0; l < LANES; l++) begin
      qmag1[l] <= qmag[l];
      qneg1[l] <= in_quot[l].qneg;
      val2[l]  <= val[l];
    end
    in_view    <= ok;
    corner_a_u <= sat32(val2[LANE_U1]);
    corner_a_v <= sat32(val2[LANE_V2]);
    corner_b_u <= sat32(val2[LANE_U2]);
    corner_b_v <= sat32(val2[LANE_V1]);
  end

endmodule

`default_nettype wire

### rtl/pinhole_box_projection.sv
// ----------------------------------------------------------------------------
// pinhole_box_projection
// projects a camera-frame point and its box corners to pixel coordinates
// ----------------------------------------------------------------------------
// One point is taken on every clock at which start is high; busy is never
// raised. Each point produces one result, strobed by done, and the receiver
// has no way to stall it. The pipeline is built around the six-lane
// restoring divider, which retires one quotient bit per pipeline stage over
// 41 stages plus a range check, with five stages before it and three after.
// Registers are written over apb and are used live by the pipeline, so the
// user must change them only while no point is in flight; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_box_projection
  import pbp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        point_x,
  input  logic [31:0]        point_y,
  input  logic [31:0]        point_z,
  output logic               done,
  output logic               in_view,
  output logic signed [31:0] corner_a_u,
  output logic signed [31:0] corner_a_v,
  output logic signed [31:0] corner_b_u,
  output logic signed [31:0] corner_b_v,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t                 cfg;
  logic                 accept;
  logic                 f_valid;
  logic                 f_zpos;
  logic [31:0]          f_zmag;
  div_in_t [LANES-1:0]  f_num;
  logic                 d_valid;
  logic                 d_zpos;
  div_out_t [LANES-1:0] d_quot;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pbp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_zpos  (f_zpos),
    .out_zmag  (f_zmag),
    .out_num   (f_num)
  );

  pbp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_zpos   (f_zpos),
    .in_zmag   (f_zmag),
    .in_num    (f_num),
    .out_valid (d_valid),
    .out_zpos  (d_zpos),
    .out_quot  (d_quot)
  );

  pbp_back #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .in_zpos    (d_zpos),
    .in_quot    (d_quot),
    .cfg        (cfg),
    .done       (done),
    .in_view    (in_view),
    .corner_a_u (corner_a_u),
    .corner_a_v (corner_a_v),
    .corner_b_u (corner_b_u),
    .corner_b_v (corner_b_v)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("item taken without a result after the pipeline latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobed with no matching item");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    done && in_view |-> (corner_a_u <= corner_b_u) && (corner_a_v <= corner_b_v))
    else $error("box corners out of order for a visible point");

endmodule

`default_nettype wire

### dv/tb_pinhole_box_projection.sv
// ----------------------------------------------------------------------------
// tb_pinhole_box_projection
// self-checking bench for the pinhole box projection pipeline
// ----------------------------------------------------------------------------
// Points go in through the start/busy command port. Registers are programmed
// over apb, and only while no point is in flight. A shadow of the registers
// feeds a 64-bit model of the projection that predicts each box when its
// point is taken. Every done strobe is checked field by field against the
// oldest predicted box. Directed points cover the field extremes, zero and
// negative depth, clamping and saturation. Random points follow, mostly
// plausible scenes under several camera settings, with random gaps on the
// sender side and one stretch without gaps.
// ----------------------------------------------------------------------------

module tb_pinhole_box_projection
  import pbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT  = 1000;
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;
  localparam logic [63:0] QUOT_LIMIT   = 64'd1 << 40;
  localparam longint      S32_MAX      = 64'sh7fffffff;
  localparam longint      S32_MIN      = -64'sh80000000;
  localparam logic [31:0] FOCAL_TYP    = 32'(800 * 65536);
  localparam logic [31:0] CU_TYP       = 32'(1024 * 65536);
  localparam logic [31:0] CV_TYP       = 32'(768 * 65536);

  typedef struct packed {
    logic        in_view;
    logic [31:0] a_u;
    logic [31:0] a_v;
    logic [31:0] b_u;
    logic [31:0] b_v;
  } box_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [31:0]        point_x;
  logic [31:0]        point_y;
  logic [31:0]        point_z;
  logic               done;
  logic               in_view;
  logic signed [31:0] corner_a_u;
  logic signed [31:0] corner_a_v;
  logic signed [31:0] corner_b_u;
  logic signed [31:0] corner_b_v;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  cfg_t   cfg_now;
  box_t   boxes_due[$];
  int     errors;
  int     n_points;
  int     n_results;
  int     n_in_view;
  int     n_settings;
  int     idle_pct;
  int     quiet_cycles;

  pinhole_box_projection DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .done       (done),
    .in_view    (in_view),
    .corner_a_u (corner_a_u),
    .corner_a_v (corner_a_v),
    .corner_b_u (corner_b_u),
    .corner_b_v (corner_b_v),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // value of one lane before saturation, Q16.16
  function automatic longint project_lane(longint coord, logic [30:0] focal, bit negate,
                                          longint shift, longint centre, longint depth);
    bit          cneg;
    bit          pneg;
    bit          tneg;
    bit          nneg;
    bit          zneg;
    bit          qneg;
    logic [63:0] cmag;
    logic [63:0] pmag;
    logic [63:0] tmag;
    logic [63:0] nmag;
    logic [63:0] zmag;
    logic [63:0] qmag;
    longint      t;
    cneg = coord < 0;
    cmag = cneg ? -coord : coord;
    pneg = negate ? !cneg : cneg;
    pmag = {33'd0, focal} * cmag;
    t = shift * 65536;
    tneg = t < 0;
    tmag = tneg ? -t : t;
    if (pmag == 0) pneg = 1'b0;
    if (pneg == tneg) begin
      nneg = pneg;
      nmag = pmag + tmag;
    end else if (pmag >= tmag) begin
      nneg = pneg;
      nmag = pmag - tmag;
    end else begin
      nneg = tneg;
      nmag = tmag - pmag;
    end
    if (depth == 0) begin
      qneg = nneg;
      qmag = (nmag == 0) ? 64'd0 : QUOT_LIMIT;
    end else begin
      zneg = depth < 0;
      zmag = zneg ? -depth : depth;
      qneg = nneg != zneg;
      qmag = nmag / zmag;
      if (qmag > QUOT_LIMIT) qmag = QUOT_LIMIT;
    end
    return (qneg ? -longint'(qmag) : longint'(qmag)) + centre;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > S32_MAX) return 32'h7fffffff;
    if (v < S32_MIN) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic box_t predict_box(logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] pz);
    box_t   b;
    longint cu;
    longint cv;
    longint h;
    longint z;
    longint su;
    longint sv;
    longint ctr_u;
    longint ctr_v;
    longint u0;
    longint v0;
    longint wb;
    longint hb;
    cu = longint'(py);
    cv = longint'(px);
    z = longint'(pz);
    h = longint'({33'd0, cfg_now.half_size});
    su = longint'(signed'(cfg_now.shift_u));
    sv = longint'(signed'(cfg_now.shift_v));
    ctr_u = longint'(signed'(cfg_now.center_u));
    ctr_v = longint'(signed'(cfg_now.center_v));
    u0 = project_lane(cu, cfg_now.focal_u, 1'b0, su, ctr_u, z);
    v0 = project_lane(cv, cfg_now.focal_v, 1'b1, sv, ctr_v, z);
    b.a_u = clip32(project_lane(cu - h, cfg_now.focal_u, 1'b0, su, ctr_u, z));
    b.b_v = clip32(project_lane(cv - h, cfg_now.focal_v, 1'b1, sv, ctr_v, z));
    b.b_u = clip32(project_lane(cu + h, cfg_now.focal_u, 1'b0, su, ctr_u, z));
    b.a_v = clip32(project_lane(cv + h, cfg_now.focal_v, 1'b1, sv, ctr_v, z));
    wb = longint'(IMAGE_WIDTH_DEF) * 65536;
    hb = longint'(IMAGE_HEIGHT_DEF) * 65536;
    b.in_view = z > 0 && u0 > -wb && u0 < wb && v0 > -hb && v0 < hb;
    return b;
  endfunction

  function automatic logic [31:0] edge_value(int k);
    case (k)
      0: return 32'h00000000;
      1: return 32'h00000001;
      2: return 32'hffffffff;
      3: return 32'h7fffffff;
      4: return 32'h80000000;
      5: return 32'h7ffffffe;
      6: return 32'h80000001;
      7: return 32'h00010000;
      8: return 32'hffff0000;
      default: return 32'h00000cce;
    endcase
  endfunction

  function automatic logic [31:0] spread(int span);
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    box_t want;
    if (!rst && done) begin
      if (boxes_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %b %h %h %h %h", $time, in_view,
                 corner_a_u, corner_a_v, corner_b_u, corner_b_v);
      end else begin
        want = boxes_due.pop_front();
        check_field("in_view", 32'(want.in_view), 32'(in_view));
        check_field("corner_a_u", want.a_u, corner_a_u);
        check_field("corner_a_v", want.a_v, corner_a_v);
        check_field("corner_b_u", want.b_u, corner_b_u);
        check_field("corner_b_v", want.b_v, corner_b_v);
        n_results++;
        if (want.in_view) n_in_view++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      point_x <= $urandom;
      point_y <= $urandom;
      point_z <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (busy);
    boxes_due.insert(boxes_due.size(), predict_box(x, y, z));
    n_points++;
  endtask

  task automatic stop_and_drain();
    start <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FOCAL_U:   cfg_now.focal_u = val[30:0];
      REG_FOCAL_V:   cfg_now.focal_v = val[30:0];
      REG_CENTER_U:  cfg_now.center_u = val;
      REG_CENTER_V:  cfg_now.center_v = val;
      REG_SHIFT_U:   cfg_now.shift_u = val;
      REG_SHIFT_V:   cfg_now.shift_v = val;
      REG_HALF_SIZE: cfg_now.half_size = val[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_camera(logic [31:0] fu, logic [31:0] fv, logic [31:0] cu,
                                logic [31:0] cv, logic [31:0] su, logic [31:0] sv,
                                logic [31:0] hs);
    stop_and_drain();
    apb_write(REG_FOCAL_U, fu);
    apb_write(REG_FOCAL_V, fv);
    apb_write(REG_CENTER_U, cu);
    apb_write(REG_CENTER_V, cv);
    apb_write(REG_SHIFT_U, su);
    apb_write(REG_SHIFT_V, sv);
    apb_write(REG_HALF_SIZE, hs);
    n_settings++;
  endtask

  // mostly plausible scenes, plus raw noise, tiny depths and field extremes
  task automatic random_point();
    int          mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    mode = $urandom_range(99);
    x = spread(131072);
    y = spread(131072);
    z = $urandom_range(13107, 327680);
    if (mode >= 60 && mode < 75) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else if (mode >= 75 && mode < 85) begin
      z = spread($urandom_range(0, 1) ? 1 : 255);
    end else if (mode >= 85) begin
      x = edge_value($urandom_range(0, 9));
      y = edge_value($urandom_range(0, 9));
      z = edge_value($urandom_range(0, 9));
    end
    send_point(x, y, z);
  endtask

  task automatic test_reset_defaults();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h00010000, 32'hffff0000, 32'h00010000);
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
  endtask

  task automatic test_directed_camera();
    program_camera(FOCAL_TYP, FOCAL_TYP, CU_TYP, CV_TYP, 32'h0, 32'h0,
                   {1'b0, HALF_SIZE_RESET});
    send_point(32'h0, 32'h0, 32'h00010000);
    send_point(32'd19661, 32'hffffcccd, 32'h00020000);
    send_point(32'h00050000, 32'h00050000, 32'h00010000);
    send_point(32'h00010000, 32'hffff0000, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h00004000, 32'h00002000, 32'hffff0000);
    send_point(32'h00010000, 32'h00010000, 32'h00000001);
    send_point(32'h00010000, 32'h00010000, 32'h7fffffff);
    send_point(32'h00010000, 32'h00010000, 32'h80000000);
    send_point(32'h7fffffff, 32'h80000000, 32'h00010000);
    send_point(32'h80000000, 32'h7fffffff, 32'h00010000);
    send_point(32'hffffffff, 32'h00000001, 32'h00010000);
  endtask

  task automatic test_extreme_config();
    program_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(32'h0, 32'h0, 32'h00010000);
    send_point(32'h7fffffff, 32'h80000000, 32'h00000001);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_point(32'h00010000, 32'h00010000, 32'h0);
    send_point($urandom, $urandom, $urandom);
    send_point($urandom, $urandom, $urandom);
    // shift terms alone, zero box size, then a write past the last register
    program_camera(32'h0, 32'h0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h0);
    apb_write(REG_UNMAPPED, 32'hffffffff);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h00010000);
    send_point(32'h0, 32'h0, 32'hffff0000);
    send_point($urandom, $urandom, 32'h7fffffff);
  endtask

  task automatic test_random_camera();
    program_camera(FOCAL_TYP, FOCAL_TYP + 32'd12345, CU_TYP, CV_TYP, spread(200 * 65536),
                   spread(200 * 65536), 32'd6554);
    for (int i = 0; i < 600; i++) begin
      if (i == 200 || i == 400) stop_and_drain();
      idle_pct = (i >= 250 && i < 400) ? 0 : 36;
      random_point();
    end
    idle_pct = 36;
  endtask

  task automatic test_random_config();
    for (int k = 0; k < 5; k++) begin
      if (k == 0) begin
        program_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        program_camera(32'($urandom_range(100, 3000) * 65536) + $urandom_range(0, 65535),
                       32'($urandom_range(100, 3000) * 65536) + $urandom_range(0, 65535),
                       spread(1500 * 65536), spread(1500 * 65536),
                       spread(200 * 65536), spread(200 * 65536),
                       $urandom_range(0, 65536));
      end
      repeat (100) random_point();
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    point_x <= '0;
    point_y <= '0;
    point_z <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_now = '0;
    cfg_now.half_size = HALF_SIZE_RESET;
    errors = 0;
    n_points = 0;
    n_results = 0;
    n_in_view = 0;
    n_settings = 1;
    idle_pct = 36;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_camera();
    test_extreme_config();
    test_random_camera();
    test_random_config();

    stop_and_drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d points projected, %0d boxes checked, %0d in view, %0d register settings",
             n_points, n_results, n_in_view, n_settings);
    $display("zero and negative depth, clamped quotients, saturated corners included");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/pbp_pkg.sv
rtl/pbp_cfg.sv
rtl/pbp_front.sv
rtl/pbp_div.sv
rtl/pbp_back.sv
rtl/pinhole_box_projection.sv
dv/tb_pinhole_box_projection.sv
